[hdl/kdv_pkg.sv]
// kdv_pkg: shared types and constants of the kick drum voice.
// Holds table sizes, fixed-point constants, register and opcode codes,
// and the structs between the sequencer, multiplier and divider.
package kdv_pkg;

    // table resolution of the sine and soft clip
    localparam int SINE_TABLE_BITS = 10;
    localparam int CLIP_TABLE_BITS = 10;

    // shared multiplier geometry
    localparam int MUL_A_W  = 34;
    localparam int MUL_B_W  = 33;
    localparam int MUL_P_W  = 64;
    localparam int MUL_SH_W = 5;

    // divider geometry for the soft clip quotient
    localparam int DVD_W     = 50;
    localparam int DVS_W     = 34;
    localparam int QUO_W     = 16;
    localparam int DIV_CNT_W = 5;

    // register indexes of the configuration port
    localparam logic [3:0] REG_AMP_DECAY   = 4'd0;
    localparam logic [3:0] REG_PITCH_DECAY = 4'd1;
    localparam logic [3:0] REG_CLICK_DECAY = 4'd2;
    localparam logic [3:0] REG_BASE_INC    = 4'd3;
    localparam logic [3:0] REG_SWEEP       = 4'd4;
    localparam logic [3:0] REG_CLICK_LEVEL = 4'd5;
    localparam logic [3:0] REG_TONE        = 4'd6;
    localparam logic [3:0] REG_DRIVE       = 4'd7;

    // opcodes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_TRIGGER = 1'b1;

    // register reset values
    localparam logic [23:0] RST_AMP_DECAY   = 24'd16776516;
    localparam logic [23:0] RST_PITCH_DECAY = 24'd16770226;
    localparam logic [23:0] RST_CLICK_DECAY = 24'd16707310;
    localparam logic [31:0] RST_BASE_INC    = 32'd4473924;
    localparam logic [15:0] RST_SWEEP       = 16'd16384;
    localparam logic [15:0] RST_CLICK_LEVEL = 16'd32768;
    localparam logic [15:0] RST_TONE        = 16'd32768;
    localparam logic [15:0] RST_DRIVE       = 16'd4096;

    // fixed-point constants
    localparam logic [16:0] ENV_ONE       = 17'd65536;
    localparam logic [16:0] SILENCE_LEVEL = 17'd66;
    localparam logic [31:0] LCG_MULT      = 32'd1103515245;
    localparam logic [31:0] LCG_INC       = 32'd12345;
    localparam logic [32:0] LP_COEF       = 33'd19661;
    localparam logic [32:0] HP_COEF       = 33'd328;
    localparam logic [32:0] OUT_GAIN      = 33'd45875;

    // sine polynomial coefficients
    localparam logic [32:0] SIN_K0 = 33'd307;
    localparam logic [16:0] SIN_K1 = 17'd5223;
    localparam logic [16:0] SIN_K2 = 17'd42334;
    localparam logic [16:0] SIN_K3 = 17'd102944;
    localparam logic [15:0] SINE_MASK =
        16'((32'hFFFF >> (16 - SINE_TABLE_BITS)) << (16 - SINE_TABLE_BITS));

    // tanh Pade coefficients
    localparam logic [33:0] PADE_C0  = 34'd553512960;
    localparam logic [32:0] PADE_N2  = 33'd17325;
    localparam logic [32:0] PADE_N4  = 33'd378;
    localparam logic [32:0] PADE_D2  = 33'd62370;
    localparam logic [32:0] PADE_D4  = 33'd3150;
    localparam logic [32:0] PADE_D6  = 33'd28;
    localparam logic [CLIP_TABLE_BITS-1:0] CLIP_LAST = '1;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
        logic [MUL_SH_W-1:0]       sh;
    } mul_op_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

endpackage

[hdl/kdv_mul.sv]
// kdv_mul: shared signed multiplier with arithmetic right shift.
// The shift floors the product. Depends on kdv_pkg.
module kdv_mul (
    input  kdv_pkg::mul_op_t                    op,
    output logic signed [kdv_pkg::MUL_P_W-1:0]  p
);

    logic signed [kdv_pkg::MUL_A_W+kdv_pkg::MUL_B_W-1:0] prod;

    // multiply, then scale down rounding toward minus infinity
    assign prod = $signed(op.a) * $signed(op.b);
    assign p    = kdv_pkg::MUL_P_W'(prod >>> op.sh);

endmodule

[hdl/kdv_div.sv]
// kdv_div: restoring divider, one quotient bit per cycle.
// Quotient must fit QUO_W bits. Depends on kdv_pkg.
module kdv_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  kdv_pkg::div_req_t req,
    output kdv_pkg::div_rsp_t rsp
);

    logic [kdv_pkg::DVS_W-1:0]     rem_reg, rem_next;
    logic [kdv_pkg::QUO_W-1:0]     quo_reg, quo_next;
    logic [kdv_pkg::DVS_W-1:0]     dvs_reg, dvs_next;
    logic [kdv_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [kdv_pkg::DVS_W:0]       shifted;
    logic [kdv_pkg::DVS_W+1:0]     diff;
    logic                          fits;

    // trial subtract of the divisor from the shifted remainder
    always_comb begin
        shifted = {rem_reg, quo_reg[kdv_pkg::QUO_W-1]};
        diff    = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = !diff[kdv_pkg::DVS_W+1];
    end

    // load on start, then advance one bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.dividend[kdv_pkg::DVD_W-1:kdv_pkg::QUO_W];
            quo_next  = req.dividend[kdv_pkg::QUO_W-1:0];
            dvs_next  = req.divisor;
            cnt_next  = kdv_pkg::DIV_CNT_W'(kdv_pkg::QUO_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[kdv_pkg::DVS_W-1:0] : shifted[kdv_pkg::DVS_W-1:0];
            quo_next = {quo_reg[kdv_pkg::QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == kdv_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

[hdl/kick_drum_voice.sv]
// kick_drum_voice: one-shot kick drum voice, sequencer over a shared multiplier.
// Trigger item: taken while idle, no result; the next item can follow at once.
// Silent tick: the zero result goes through S_DONE to the output register.
// Sounding tick: the result is built in the steps S_AMP to S_OUT, which use the one
// multiplier, with the one-bit-per-cycle divider between S_DGO and S_LP, then S_DONE;
// the next item is taken back in S_IDLE; S_DONE waits while the output is full and m_ready is low.
// Reset (aresetn, synchronous): registers to defaults, voice silent, filters zero.
// Depends on kdv_pkg, kdv_mul, kdv_div.
module kick_drum_voice (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [15:0]        s_velocity,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_sample_out,
    output logic               m_voice_active,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE, S_AMP, S_PITCH, S_CENV, S_FACT, S_INC, S_LCG, S_ST2,
        S_S1, S_S2, S_S3, S_S4, S_C1, S_C2, S_M1, S_M2, S_M3, S_DRV,
        S_X2, S_X4, S_X6, S_N1, S_N2, S_D1, S_D2, S_D3, S_NX,
        S_DGO, S_DWAIT, S_LP, S_HP, S_OUT, S_DONE
    } state_t;

    localparam int CB = kdv_pkg::CLIP_TABLE_BITS;

    // configuration registers
    logic [23:0] amp_decay_reg, pitch_decay_reg, click_decay_reg;
    logic [31:0] base_inc_reg;
    logic [15:0] sweep_reg, click_level_reg, tone_reg, drive_reg;

    // voice state and work registers
    state_t             state_reg, state_next;
    logic               active_reg, active_next;
    logic [31:0]        phase_reg, phase_next;
    logic [16:0]        amp_reg, amp_next;
    logic [16:0]        pitch_reg, pitch_next;
    logic [16:0]        cenv_reg, cenv_next;
    logic [15:0]        vel_reg, vel_next;
    logic [31:0]        seed_reg, seed_next;
    logic signed [23:0] lp_reg, lp_next;
    logic signed [23:0] hp_reg, hp_next;
    logic [20:0]        factor_reg, factor_next;
    logic [16:0]        t_reg, t_next;
    logic [16:0]        t2_reg, t2_next;
    logic [16:0]        acc_reg, acc_next;
    logic [1:0]         quad_reg, quad_next;
    logic signed [15:0] body_reg, body_next;
    logic signed [16:0] clk_reg, clk_next;
    logic signed [21:0] mix_reg, mix_next;
    logic [13:0]        x_reg, x_next;
    logic               neg_reg, neg_next;
    logic [16:0]        x2_reg, x2_next;
    logic [20:0]        x4_reg, x4_next;
    logic [24:0]        x6_reg, x6_next;
    logic [32:0]        num_reg, num_next;
    logic [33:0]        den_reg, den_next;
    logic [kdv_pkg::DVD_W-1:0] dvd_reg, dvd_next;
    logic signed [15:0] clip_reg, clip_next;
    logic signed [15:0] res_sample_reg, res_sample_next;
    logic               res_active_reg, res_active_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [15:0] m_sample_reg, m_sample_next;
    logic               m_active_reg, m_active_next;

    // datapath helpers
    kdv_pkg::mul_op_t                   mul_op;
    logic signed [kdv_pkg::MUL_P_W-1:0] mul_p;
    kdv_pkg::div_req_t                  div_req;
    kdv_pkg::div_rsp_t                  div_rsp;
    logic [15:0]        sin_p;
    logic [14:0]        sin_r;
    logic [16:0]        sin_t;
    logic signed [15:0] noise;
    logic [21:0]        drv_mag;
    logic [21:0]        drv_idx;
    logic [CB-1:0]      clip_idx;
    logic [13:0]        clip_x;
    logic [15:0]        sat_mag;
    logic [15:0]        quo_sat;
    logic signed [23:0] s23;
    logic signed [24:0] lp_diff, hp_diff, out_diff;

    kdv_mul u_mul (
        .op (mul_op),
        .p  (mul_p)
    );

    kdv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration writes; indexes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amp_decay_reg   <= kdv_pkg::RST_AMP_DECAY;
            pitch_decay_reg <= kdv_pkg::RST_PITCH_DECAY;
            click_decay_reg <= kdv_pkg::RST_CLICK_DECAY;
            base_inc_reg    <= kdv_pkg::RST_BASE_INC;
            sweep_reg       <= kdv_pkg::RST_SWEEP;
            click_level_reg <= kdv_pkg::RST_CLICK_LEVEL;
            tone_reg        <= kdv_pkg::RST_TONE;
            drive_reg       <= kdv_pkg::RST_DRIVE;
        end else if (cfg_valid) begin
            case (cfg_index)
                kdv_pkg::REG_AMP_DECAY:   amp_decay_reg   <= cfg_data[23:0];
                kdv_pkg::REG_PITCH_DECAY: pitch_decay_reg <= cfg_data[23:0];
                kdv_pkg::REG_CLICK_DECAY: click_decay_reg <= cfg_data[23:0];
                kdv_pkg::REG_BASE_INC:    base_inc_reg    <= cfg_data;
                kdv_pkg::REG_SWEEP:       sweep_reg       <= cfg_data[15:0];
                kdv_pkg::REG_CLICK_LEVEL: click_level_reg <= cfg_data[15:0];
                kdv_pkg::REG_TONE:        tone_reg        <= cfg_data[15:0];
                kdv_pkg::REG_DRIVE:       drive_reg       <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sine table address, noise value and soft clip address
    always_comb begin
        sin_p    = phase_reg[31:16] & kdv_pkg::SINE_MASK;
        sin_r    = {1'b0, sin_p[13:0]};
        if (sin_p[14]) begin
            sin_r = 15'(15'd16384 - sin_r);
        end
        sin_t    = {sin_r, 2'b00};
        noise    = {~seed_reg[30], seed_reg[29:16], 1'b0};
        drv_mag  = mix_reg[21] ? 22'(-mix_reg) : 22'(mix_reg);
        drv_idx  = drv_mag >> (17 - CB);
        clip_idx = (drv_idx > 22'(kdv_pkg::CLIP_LAST)) ? kdv_pkg::CLIP_LAST
                                                        : drv_idx[CB-1:0];
        clip_x   = 14'((32'(clip_idx) << (17 - CB)) >> 3);
        sat_mag  = (mul_p > 64'sd32767) ? 16'd32767 : mul_p[15:0];
        quo_sat  = (div_rsp.quotient > 16'd32767) ? 16'd32767 : div_rsp.quotient;
        s23      = {clip_reg, 8'h00};
        lp_diff  = 25'(s23) - 25'(lp_reg);
        hp_diff  = 25'(lp_reg) - 25'(hp_reg);
        out_diff = 25'(lp_reg) - 25'(hp_reg);
    end

    // multiplier operands for each step
    always_comb begin
        mul_op.a  = '0;
        mul_op.b  = '0;
        mul_op.sh = '0;
        case (state_reg)
            S_AMP: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, amp_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, amp_decay_reg}));
                mul_op.sh = 5'd24;
            end
            S_PITCH: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, pitch_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, pitch_decay_reg}));
                mul_op.sh = 5'd24;
            end
            S_CENV: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, cenv_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, click_decay_reg}));
                mul_op.sh = 5'd24;
            end
            S_FACT: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, sweep_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, pitch_reg}));
                mul_op.sh = 5'd12;
            end
            S_INC: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, base_inc_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, factor_reg}));
                mul_op.sh = 5'd16;
            end
            S_LCG: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, seed_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, kdv_pkg::LCG_MULT}));
            end
            S_ST2: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, sin_t}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, sin_t}));
                mul_op.sh = 5'd16;
            end
            S_S1: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, t2_reg}));
                mul_op.b  = $signed(kdv_pkg::SIN_K0);
                mul_op.sh = 5'd16;
            end
            S_S2, S_S3: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, t2_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, acc_reg}));
                mul_op.sh = 5'd16;
            end
            S_S4: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, t_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, acc_reg}));
                mul_op.sh = 5'd17;
            end
            S_C1: begin
                mul_op.a  = kdv_pkg::MUL_A_W'(noise);
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, cenv_reg}));
                mul_op.sh = 5'd16;
            end
            S_C2: begin
                mul_op.a  = kdv_pkg::MUL_A_W'(clk_reg);
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, click_level_reg}));
                mul_op.sh = 5'd16;
            end
            S_M1: begin
                mul_op.a  = kdv_pkg::MUL_A_W'(body_reg);
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0,
                                17'(kdv_pkg::ENV_ONE - {2'b00, tone_reg[15:1]})}));
                mul_op.sh = 5'd16;
            end
            S_M2: begin
                mul_op.a  = kdv_pkg::MUL_A_W'(mix_reg);
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, amp_reg}));
                mul_op.sh = 5'd16;
            end
            S_M3: begin
                mul_op.a  = kdv_pkg::MUL_A_W'(mix_reg);
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, vel_reg}));
                mul_op.sh = 5'd16;
            end
            S_DRV: begin
                mul_op.a  = kdv_pkg::MUL_A_W'(mix_reg);
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, drive_reg}));
                mul_op.sh = 5'd12;
            end
            S_X2: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, clip_x}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, clip_x}));
                mul_op.sh = 5'd12;
            end
            S_X4: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, x2_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, x2_reg}));
                mul_op.sh = 5'd12;
            end
            S_X6: begin
                mul_op.a  = kdv_pkg::MUL_A_W'($signed({1'b0, x4_reg}));
                mul_op.b  = kdv_pkg::MUL_B_W'($signed({1'b0, x2_reg}));
                mul_op.sh = 5'd12;
            end
            S_N1: begin
                mul_op.a = kdv_pkg::MUL_A_W'($signed({1'b0, x2_reg}));
                mul_op.b = $signed(kdv_pkg::PADE_N2);
            end
            S_N2: begin
                mul_op.a = kdv_pkg::MUL_A_W'($signed({1'b0, x4_reg}));
                mul_op.b = $signed(kdv_pkg::PADE_N4);
            end
            S_D1: begin
                mul_op.a = kdv_pkg::MUL_A_W'($signed({1'b0, x2_reg}));
                mul_op.b = $signed(kdv_pkg::PADE_D2);
            end
            S_D2: begin
                mul_op.a = kdv_pkg::MUL_A_W'($signed({1'b0, x4_reg}));
                mul_op.b = $signed(kdv_pkg::PADE_D4);
            end
            S_D3: begin
                mul_op.a = kdv_pkg::MUL_A_W'($signed({1'b0, x6_reg}));
                mul_op.b = $signed(kdv_pkg::PADE_D6);
            end
            S_NX: begin
                mul_op.a = kdv_pkg::MUL_A_W'($signed({1'b0, num_reg}));
                mul_op.b = kdv_pkg::MUL_B_W'($signed({1'b0, x_reg}));
            end
            S_LP: begin
                mul_op.a  = kdv_pkg::MUL_A_W'(lp_diff);
                mul_op.b  = $signed(kdv_pkg::LP_COEF);
                mul_op.sh = 5'd16;
            end
            S_HP: begin
                mul_op.a  = kdv_pkg::MUL_A_W'(hp_diff);
                mul_op.b  = $signed(kdv_pkg::HP_COEF);
                mul_op.sh = 5'd16;
            end
            S_OUT: begin
                mul_op.a  = kdv_pkg::MUL_A_W'(out_diff);
                mul_op.b  = $signed(kdv_pkg::OUT_GAIN);
                mul_op.sh = 5'd24;
            end
            default: ;
        endcase
    end

    // divider request
    always_comb begin
        div_req.start    = (state_reg == S_DGO);
        div_req.dividend = dvd_reg;
        div_req.divisor  = den_reg;
    end

    // sequencer: next state and register updates
    always_comb begin
        state_next      = state_reg;
        active_next     = active_reg;
        phase_next      = phase_reg;
        amp_next        = amp_reg;
        pitch_next      = pitch_reg;
        cenv_next       = cenv_reg;
        vel_next        = vel_reg;
        seed_next       = seed_reg;
        lp_next         = lp_reg;
        hp_next         = hp_reg;
        factor_next     = factor_reg;
        t_next          = t_reg;
        t2_next         = t2_reg;
        acc_next        = acc_reg;
        quad_next       = quad_reg;
        body_next       = body_reg;
        clk_next        = clk_reg;
        mix_next        = mix_reg;
        x_next          = x_reg;
        neg_next        = neg_reg;
        x2_next         = x2_reg;
        x4_next         = x4_reg;
        x6_next         = x6_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        dvd_next        = dvd_reg;
        clip_next       = clip_reg;
        res_sample_next = res_sample_reg;
        res_active_next = res_active_reg;
        m_valid_next    = m_valid_reg;
        m_sample_next   = m_sample_reg;
        m_active_next   = m_active_reg;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == kdv_pkg::OP_TRIGGER) begin
                        vel_next    = s_velocity;
                        active_next = 1'b1;
                        phase_next  = '0;
                        amp_next    = kdv_pkg::ENV_ONE;
                        pitch_next  = kdv_pkg::ENV_ONE;
                        cenv_next   = kdv_pkg::ENV_ONE;
                        seed_next   = '0;
                    end else if (active_reg) begin
                        state_next = S_AMP;
                    end else begin
                        res_sample_next = '0;
                        res_active_next = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end
            // decay the three envelopes
            S_AMP: begin
                amp_next   = mul_p[16:0];
                state_next = S_PITCH;
            end
            S_PITCH: begin
                pitch_next = mul_p[16:0];
                state_next = S_CENV;
            end
            S_CENV: begin
                cenv_next  = mul_p[16:0];
                state_next = S_FACT;
            end
            // silence check, then pitch sweep factor
            S_FACT: begin
                if (amp_reg < kdv_pkg::SILENCE_LEVEL) begin
                    active_next     = 1'b0;
                    res_sample_next = '0;
                    res_active_next = 1'b0;
                    state_next      = S_DONE;
                end else begin
                    factor_next = 21'(21'd65536 + mul_p[20:0]);
                    state_next  = S_INC;
                end
            end
            S_INC: begin
                phase_next = phase_reg + mul_p[31:0];
                state_next = S_LCG;
            end
            S_LCG: begin
                seed_next  = mul_p[31:0] + kdv_pkg::LCG_INC;
                state_next = S_ST2;
            end
            // quarter-wave sine polynomial
            S_ST2: begin
                t_next     = sin_t;
                quad_next  = sin_p[15:14];
                t2_next    = mul_p[16:0];
                state_next = S_S1;
            end
            S_S1: begin
                acc_next   = kdv_pkg::SIN_K1 - mul_p[16:0];
                state_next = S_S2;
            end
            S_S2: begin
                acc_next   = kdv_pkg::SIN_K2 - mul_p[16:0];
                state_next = S_S3;
            end
            S_S3: begin
                acc_next   = kdv_pkg::SIN_K3 - mul_p[16:0];
                state_next = S_S4;
            end
            S_S4: begin
                body_next  = quad_reg[1] ? -$signed(sat_mag) : $signed(sat_mag);
                state_next = S_C1;
            end
            // shape the noise click
            S_C1: begin
                clk_next   = mul_p[16:0];
                state_next = S_C2;
            end
            S_C2: begin
                clk_next   = mul_p[16:0];
                state_next = S_M1;
            end
            // mix, amplitude, velocity, drive
            S_M1: begin
                mix_next   = 22'(mul_p) + 22'(clk_reg);
                state_next = S_M2;
            end
            S_M2: begin
                mix_next   = mul_p[21:0];
                state_next = S_M3;
            end
            S_M3: begin
                mix_next   = mul_p[21:0];
                state_next = S_DRV;
            end
            S_DRV: begin
                mix_next   = mul_p[21:0];
                state_next = S_X2;
            end
            // soft clip entry: powers of x, Pade terms
            S_X2: begin
                x_next     = clip_x;
                neg_next   = mix_reg[21];
                x2_next    = mul_p[16:0];
                state_next = S_X4;
            end
            S_X4: begin
                x4_next    = mul_p[20:0];
                state_next = S_X6;
            end
            S_X6: begin
                x6_next    = mul_p[24:0];
                state_next = S_N1;
            end
            S_N1: begin
                num_next   = 33'(kdv_pkg::PADE_C0 + 34'(mul_p[32:0]) + 34'(x6_reg));
                state_next = S_N2;
            end
            S_N2: begin
                num_next   = num_reg + mul_p[32:0];
                state_next = S_D1;
            end
            S_D1: begin
                den_next   = kdv_pkg::PADE_C0 + mul_p[33:0];
                state_next = S_D2;
            end
            S_D2: begin
                den_next   = den_reg + mul_p[33:0];
                state_next = S_D3;
            end
            S_D3: begin
                den_next   = den_reg + mul_p[33:0];
                state_next = S_NX;
            end
            S_NX: begin
                dvd_next   = {mul_p[kdv_pkg::DVD_W-4:0], 3'b000};
                state_next = S_DGO;
            end
            S_DGO: begin
                state_next = S_DWAIT;
            end
            S_DWAIT: begin
                if (div_rsp.done) begin
                    clip_next  = neg_reg ? -$signed(quo_sat) : $signed(quo_sat);
                    state_next = S_LP;
                end
            end
            // low-pass, DC follower, output gain
            S_LP: begin
                lp_next    = lp_reg + mul_p[23:0];
                state_next = S_HP;
            end
            S_HP: begin
                hp_next    = hp_reg + mul_p[23:0];
                state_next = S_OUT;
            end
            S_OUT: begin
                if (mul_p > 64'sd32767) begin
                    res_sample_next = 16'sd32767;
                end else if (mul_p < -64'sd32768) begin
                    res_sample_next = -16'sd32768;
                end else begin
                    res_sample_next = mul_p[15:0];
                end
                res_active_next = 1'b1;
                state_next      = S_DONE;
            end
            // hand the item to the output register when free
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_sample_next = res_sample_reg;
                    m_active_next = res_active_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            active_reg  <= 1'b0;
            phase_reg   <= '0;
            amp_reg     <= '0;
            pitch_reg   <= '0;
            cenv_reg    <= '0;
            vel_reg     <= '0;
            seed_reg    <= '0;
            lp_reg      <= '0;
            hp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            active_reg  <= active_next;
            phase_reg   <= phase_next;
            amp_reg     <= amp_next;
            pitch_reg   <= pitch_next;
            cenv_reg    <= cenv_next;
            vel_reg     <= vel_next;
            seed_reg    <= seed_next;
            lp_reg      <= lp_next;
            hp_reg      <= hp_next;
            m_valid_reg <= m_valid_next;
        end
        factor_reg     <= factor_next;
        t_reg          <= t_next;
        t2_reg         <= t2_next;
        acc_reg        <= acc_next;
        quad_reg       <= quad_next;
        body_reg       <= body_next;
        clk_reg        <= clk_next;
        mix_reg        <= mix_next;
        x_reg          <= x_next;
        neg_reg        <= neg_next;
        x2_reg         <= x2_next;
        x4_reg         <= x4_next;
        x6_reg         <= x6_next;
        num_reg        <= num_next;
        den_reg        <= den_next;
        dvd_reg        <= dvd_next;
        clip_reg       <= clip_next;
        res_sample_reg <= res_sample_next;
        res_active_reg <= res_active_next;
        m_sample_reg   <= m_sample_next;
        m_active_reg   <= m_active_next;
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_sample_out   = m_sample_reg;
    assign m_voice_active = m_active_reg;

endmodule

[dv/kdv_checker.sv]
// kdv_checker: watches the item, result and register channels of kick_drum_voice,
// predicts each sample from its own copy of the voice state and compares.
// Depends on kdv_pkg.
`timescale 1ns / 100ps
module kdv_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_opcode,
    input  logic [15:0]        s_velocity,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [15:0] m_sample_out,
    input  logic               m_voice_active,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [3:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic signed [15:0] sample;
        logic               active;
    } sample_t;

    sample_t expected_samples[$];

    // register copy
    logic [23:0] amp_mult, pitch_mult, click_mult;
    logic [31:0] base_inc;
    logic [15:0] sweep, click_gain, tone, drive;

    // voice copy
    logic        sounding;
    logic [31:0] phase;
    logic [16:0] amp_e, pitch_e, click_e;
    logic [15:0] vel;
    logic [31:0] seed;
    int          lp, hp;

    // product shifted right, rounded toward minus infinity
    function automatic longint mulsh(longint a, longint b, int sh);
        return (a * b) >>> sh;
    endfunction

    function automatic logic [16:0] decay(logic [16:0] e, logic [23:0] m);
        longint unsigned p;
        p = longint'(e) * longint'(m);
        return 17'(p >> 24);
    endfunction

    function automatic longint sine_of(logic [31:0] ph);
        longint unsigned idx, p, quad, r, t, t2, acc, s;
        idx = ph >> (32 - kdv_pkg::SINE_TABLE_BITS);
        p = (idx << (16 - kdv_pkg::SINE_TABLE_BITS)) & 64'hFFFF;
        quad = p >> 14;
        r = p & 64'h3FFF;
        if (quad[0]) r = 16384 - r;
        t = r << 2;
        t2 = (t * t) >> 16;
        acc = 5223 - ((t2 * 307) >> 16);
        acc = 42334 - ((t2 * acc) >> 16);
        acc = 102944 - ((t2 * acc) >> 16);
        s = ((t * acc) >> 16) >> 1;
        if (s > 32767) s = 32767;
        return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    // Pade tanh of the lower edge of the table cell that holds |x|
    function automatic longint clip_of(longint x);
        longint unsigned mag, idx, xe, x2, x4, x6, num, den, y;
        mag = (x < 0) ? longint'(-x) : x;
        idx = mag >> (17 - kdv_pkg::CLIP_TABLE_BITS);
        if (idx > (64'd1 << kdv_pkg::CLIP_TABLE_BITS) - 1)
            idx = (64'd1 << kdv_pkg::CLIP_TABLE_BITS) - 1;
        xe = (idx << (17 - kdv_pkg::CLIP_TABLE_BITS)) >> 3;
        x2 = (xe * xe) >> 12;
        x4 = (x2 * x2) >> 12;
        x6 = (x4 * x2) >> 12;
        num = 135135 * 4096 + 17325 * x2 + 378 * x4 + x6;
        den = 135135 * 4096 + 62370 * x2 + 3150 * x4 + 28 * x6;
        y = ((num * xe) << 3) / den;
        if (y > 32767) y = 32767;
        return (x < 0) ? -longint'(y) : longint'(y);
    endfunction

    // advance the voice by one item, queue the sample a tick yields
    task automatic advance_voice(logic op, logic [15:0] v);
        sample_t         res;
        longint unsigned fac, inc;
        longint          body, noise, click, mix, drv, d, y;
        if (op == kdv_pkg::OP_TRIGGER) begin
            vel = v;
            sounding = 1'b1;
            phase = '0;
            amp_e = kdv_pkg::ENV_ONE;
            pitch_e = kdv_pkg::ENV_ONE;
            click_e = kdv_pkg::ENV_ONE;
            seed = '0;
            return;
        end
        res.sample = '0;
        res.active = 1'b0;
        if (sounding) begin
            amp_e = decay(amp_e, amp_mult);
            pitch_e = decay(pitch_e, pitch_mult);
            click_e = decay(click_e, click_mult);
            if (amp_e < kdv_pkg::SILENCE_LEVEL) begin
                sounding = 1'b0;
            end else begin
                fac = 65536 + ((longint'(sweep) * longint'(pitch_e)) >> 12);
                inc = (longint'(base_inc) * fac) >> 16;
                phase = phase + 32'(inc);
                body = sine_of(phase);
                seed = seed * kdv_pkg::LCG_MULT + kdv_pkg::LCG_INC;
                noise = longint'(((seed >> 16) & 32'h7FFF) * 2) - 32768;
                click = mulsh(noise, longint'(click_e), 16);
                click = mulsh(click, longint'(click_gain), 16);
                mix = mulsh(body, 65536 - longint'(tone >> 1), 16) + click;
                mix = mulsh(mix, longint'(amp_e), 16);
                mix = mulsh(mix, longint'(vel), 16);
                drv = mulsh(mix, longint'(drive), 12);
                lp = lp + int'(mulsh(clip_of(drv) * 256 - lp, 19661, 16));
                hp = hp + int'(mulsh(longint'(lp) - hp, 328, 16));
                d = longint'(lp) - hp;
                y = mulsh(d, 45875, 24);
                if (y > 32767) y = 32767;
                if (y < -32768) y = -32768;
                res.sample = 16'(y);
                res.active = 1'b1;
            end
        end
        expected_samples.push_back(res);
    endtask

    assign pending = expected_samples.size();

    always @(posedge aclk) begin
        sample_t want;
        if (!aresetn) begin
            amp_mult <= kdv_pkg::RST_AMP_DECAY;
            pitch_mult <= kdv_pkg::RST_PITCH_DECAY;
            click_mult <= kdv_pkg::RST_CLICK_DECAY;
            base_inc <= kdv_pkg::RST_BASE_INC;
            sweep <= kdv_pkg::RST_SWEEP;
            click_gain <= kdv_pkg::RST_CLICK_LEVEL;
            tone <= kdv_pkg::RST_TONE;
            drive <= kdv_pkg::RST_DRIVE;
            errors <= 0;
            sounding = 1'b0;
            phase = '0;
            amp_e = '0;
            pitch_e = '0;
            click_e = '0;
            vel = '0;
            seed = '0;
            lp = 0;
            hp = 0;
            expected_samples.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    kdv_pkg::REG_AMP_DECAY:   amp_mult <= cfg_data[23:0];
                    kdv_pkg::REG_PITCH_DECAY: pitch_mult <= cfg_data[23:0];
                    kdv_pkg::REG_CLICK_DECAY: click_mult <= cfg_data[23:0];
                    kdv_pkg::REG_BASE_INC:    base_inc <= cfg_data;
                    kdv_pkg::REG_SWEEP:       sweep <= cfg_data[15:0];
                    kdv_pkg::REG_CLICK_LEVEL: click_gain <= cfg_data[15:0];
                    kdv_pkg::REG_TONE:        tone <= cfg_data[15:0];
                    kdv_pkg::REG_DRIVE:       drive <= cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                advance_voice(s_opcode, s_velocity);
            // compare each sample with the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    errors <= errors + 1;
                    if (errors < 10)
                        $display("unexpected sample %0d active %0b",
                                 m_sample_out, m_voice_active);
                end else begin
                    want = expected_samples.pop_front();
                    if (want.sample !== m_sample_out || want.active !== m_voice_active) begin
                        errors <= errors + 1;
                        if (errors < 10)
                            $display("sample mismatch: expected %0d/%0b got %0d/%0b",
                                     want.sample, want.active, m_sample_out,
                                     m_voice_active);
                    end
                end
            end
        end
    end

endmodule

[dv/tb_kick_drum_voice.sv]
// tb_kick_drum_voice: stimulus and verdict for kick_drum_voice.
// Drives hits and ticks under several idling phases and register settings;
// depends on kdv_pkg, kick_drum_voice and kdv_checker.
`timescale 1ns / 100ps
module tb_kick_drum_voice;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = kdv_pkg::OP_TICK;
    logic [15:0]        s_velocity = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_sample_out;
    logic               m_voice_active;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    int                 errors, pending;
    int                 send_idle_pct = 0, recv_stall_pct = 0;
    bit                 hold_off = 1'b0;
    int                 quiet_cycles = 0;

    kick_drum_voice uut (.*);
    kdv_checker u_checker (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        int n;
        if (hold_off) begin
            m_ready <= 1'b0;
            for (n = 0; n < 400; n++) @(posedge aclk);
            hold_off = 1'b0;
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // watchdog: end the run if nothing moves for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= 20000) begin
            $display("kick_drum_voice test failed");
            $finish;
        end
    end

    task automatic send_item(logic op, logic [15:0] v);
        bit got;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_velocity <= v;
        do begin
            @(negedge aclk);
            got = s_ready;
            @(posedge aclk);
        end while (!got);
    endtask

    task automatic write_reg(logic [3:0] idx, logic [31:0] value);
        bit got;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do begin
            @(negedge aclk);
            got = cfg_ready;
            @(posedge aclk);
        end while (!got);
        cfg_valid <= 1'b0;
    endtask

    // wait until every sample is back and the block has gone quiet
    task automatic drain();
        int n;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        for (n = 0; n < 100; n++) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi, logic [31:0] typ);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            2: return typ;
            default: return $urandom();
        endcase
    endfunction

    // pick a new setting; mostly long decays so the voice keeps sounding
    task automatic program_voice();
        logic [31:0] amp;
        case ($urandom_range(5))
            0: amp = 32'h00FF_FFFF;
            1: amp = 32'h0;
            default: amp = {8'h00, 8'hFF, 8'($urandom_range(255)), 8'($urandom_range(255))};
        endcase
        write_reg(kdv_pkg::REG_AMP_DECAY, amp);
        write_reg(kdv_pkg::REG_PITCH_DECAY,
                  pick(0, 32'hFFFF_FFFF, 32'(kdv_pkg::RST_PITCH_DECAY)));
        write_reg(kdv_pkg::REG_CLICK_DECAY,
                  pick(0, 32'hFFFF_FFFF, 32'(kdv_pkg::RST_CLICK_DECAY)));
        write_reg(kdv_pkg::REG_BASE_INC, pick(0, 32'hFFFF_FFFF, kdv_pkg::RST_BASE_INC));
        write_reg(kdv_pkg::REG_SWEEP, pick(0, 32'hFFFF, 32'(kdv_pkg::RST_SWEEP)));
        write_reg(kdv_pkg::REG_CLICK_LEVEL,
                  pick(0, 32'hFFFF, 32'(kdv_pkg::RST_CLICK_LEVEL)));
        write_reg(kdv_pkg::REG_TONE, pick(0, 32'hFFFF, 32'(kdv_pkg::RST_TONE)));
        write_reg(kdv_pkg::REG_DRIVE, pick(0, 32'hFFFF, 32'(kdv_pkg::RST_DRIVE)));
        write_reg(4'($urandom_range(15, 8)), $urandom());
    endtask

    // one hit with random content followed by a run of ticks
    task automatic play_hit(output int count);
        logic [15:0] v;
        int          n, ticks;
        case ($urandom_range(4))
            0: v = 16'hFFFF;
            1: v = 16'h0000;
            default: v = 16'($urandom());
        endcase
        send_item(kdv_pkg::OP_TRIGGER, v);
        ticks = $urandom_range(60, 3);
        for (n = 0; n < ticks; n++) send_item(kdv_pkg::OP_TICK, 16'($urandom()));
        count = ticks + 1;
    endtask

    initial begin
        int phase_no, sent, n;
        int idle_tab[4]  = '{0, 70, 0, 32};
        int stall_tab[4] = '{0, 0, 70, 32};
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: silent tick, extreme velocities, clip beyond the table
        send_item(kdv_pkg::OP_TICK, 16'hFFFF);
        send_item(kdv_pkg::OP_TRIGGER, 16'h0000);
        for (n = 0; n < 3; n++) send_item(kdv_pkg::OP_TICK, 16'h0000);
        send_item(kdv_pkg::OP_TRIGGER, 16'hFFFF);
        for (n = 0; n < 6; n++) send_item(kdv_pkg::OP_TICK, 16'h0000);
        drain();
        write_reg(kdv_pkg::REG_DRIVE, 32'hFFFF_FFFF);
        write_reg(kdv_pkg::REG_CLICK_LEVEL, 32'h0000_FFFF);
        send_item(kdv_pkg::OP_TRIGGER, 16'hFFFF);
        for (n = 0; n < 5; n++) send_item(kdv_pkg::OP_TICK, 16'h1234);
        drain();
        // amplitude falls below threshold at once
        write_reg(kdv_pkg::REG_AMP_DECAY, 32'h0);
        send_item(kdv_pkg::OP_TRIGGER, 16'h8000);
        for (n = 0; n < 3; n++) send_item(kdv_pkg::OP_TICK, 16'h0);
        drain();

        // random phases under each idling pattern
        for (phase_no = 0; phase_no < 8; phase_no++) begin
            send_idle_pct = idle_tab[phase_no % 4];
            recv_stall_pct = stall_tab[phase_no % 4];
            program_voice();
            if (phase_no == 1) hold_off = 1'b1;
            sent = 0;
            while (sent < 160) begin
                if ($urandom_range(9) == 0) begin
                    send_item(1'($urandom_range(1)), 16'($urandom()));
                    sent++;
                end else begin
                    play_hit(n);
                    sent += n;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("kick_drum_voice test passed");
        else
            $display("kick_drum_voice test failed");
        $finish;
    end
endmodule
